>>> sv/sparse_image_sector_translator_assert.svh
// ----------------------------------------------------------------------------
// sparse image sector translator assertion macros
// shared forms for the concurrent checks of the translator
// ----------------------------------------------------------------------------
`ifndef SPARSE_IMAGE_SECTOR_TRANSLATOR_ASSERT_SVH
`define SPARSE_IMAGE_SECTOR_TRANSLATOR_ASSERT_SVH

// same-cycle implication, off while reset is low
`define SIST_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sist assertion failed");

// next-cycle implication, off while reset is low
`define SIST_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sist assertion failed");

`endif

>>> sv/sist_pkg.sv
// ----------------------------------------------------------------------------
// sist_pkg
// widths, codes and shared types of the sparse image sector translator
// ----------------------------------------------------------------------------
package sist_pkg;

    // field widths
    localparam int SECTOR_W     = 40;
    localparam int SECTOR_SHIFT = 9;
    localparam int OFS_W        = SECTOR_W + SECTOR_SHIFT;
    localparam int WIDX_W       = 12;
    localparam int VAL_W        = 32;
    localparam int EB_W         = 32;
    localparam int ES_W         = 24;
    localparam int BS_W         = 24;
    localparam int DOFS_W       = 32;
    localparam int CENT_W       = 13;
    localparam int WITHIN_W     = EB_W - SECTOR_SHIFT;
    localparam int BIT_W        = 3;
    localparam int BMP_OFS_W    = WITHIN_W - BIT_W;
    localparam int SPAN_W       = ES_W + 1;
    localparam int PROD_W       = VAL_W + SPAN_W;
    localparam int ADDR_W       = 64;
    localparam int STATUS_W     = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    localparam logic [VAL_W-1:0] SLOT_UNALLOC = 32'hffff_ffff;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_BYTES    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_SECTORS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BITMAP_SECTORS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_START      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CATALOG_ENTRIES = 3'd4;

    // configuration reset values
    localparam logic [EB_W-1:0]   RST_EXTENT_BYTES    = 32'd65536;
    localparam logic [ES_W-1:0]   RST_EXTENT_SECTORS  = 24'd128;
    localparam logic [BS_W-1:0]   RST_BITMAP_SECTORS  = 24'd1;
    localparam logic [DOFS_W-1:0] RST_DATA_START      = 32'd512;
    localparam logic [CENT_W-1:0] RST_CATALOG_ENTRIES = 13'd0;

    typedef enum logic {
        OP_WRITE     = 1'b0,
        OP_TRANSLATE = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_MAPPED  = 2'd0,
        ST_UNALLOC = 2'd1,
        ST_OUTSIDE = 2'd2,
        ST_WRITTEN = 2'd3
    } t_status;

    // beat control carried through the divider
    typedef struct packed {
        t_op               op;
        logic              bad;
        logic [WIDX_W-1:0] widx;
        logic [VAL_W-1:0]  wval;
    } t_ctl;

    // catalog lookup result
    typedef struct packed {
        t_op                 op;
        logic                outside;
        logic [VAL_W-1:0]    slot;
        logic [WITHIN_W-1:0] ext_sec;
    } t_look;

endpackage

>>> sv/sparse_image_sector_translator.sv
// ----------------------------------------------------------------------------
// sparse_image_sector_translator
// virtual sector to sparse image byte offsets, with a writable extent catalog
// ----------------------------------------------------------------------------
// Each input beat is either a catalog write or a sector translation and gives
// exactly one result beat, in order. The block takes one beat per cycle while
// o_stall is low; a beat passes IDX_W + 5 registers on its way to the outputs:
// the extent index is found by a restoring divider with one compare-subtract
// stage per index bit (IDX_W stages behind one range-check stage), then one
// stage on the single port catalog memory, then a multiply stage, a base add
// stage and the output register. Every stage holds its own valid bit, so empty
// stages fill while the output waits and input stall rises only when the whole
// pipe is full. Catalog entries come up undefined after reset and there is no
// clearing pass: write an entry before translating a sector that lands on it.
// The user must write configuration registers only while no beat is in
// flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module sparse_image_sector_translator #(
    parameter int CATALOG_DEPTH = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_wr_en,
    input  logic [sist_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sist_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input beats
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_operation,
    input  logic [sist_pkg::WIDX_W-1:0]     i_entry_index,
    input  logic [sist_pkg::VAL_W-1:0]      i_entry_value,
    input  logic [sist_pkg::SECTOR_W-1:0]   i_sector,
    // result beats
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [sist_pkg::STATUS_W-1:0]   o_status,
    output logic [sist_pkg::ADDR_W-1:0]     o_bitmap_byte_address,
    output logic [sist_pkg::BIT_W-1:0]      o_bit_index,
    output logic [sist_pkg::ADDR_W-1:0]     o_block_address
);
    import sist_pkg::*;

    // index width; a one-entry catalog still gets a one-bit quotient
    localparam int IDX_W = (CATALOG_DEPTH > 1) ? $clog2(CATALOG_DEPTH) : 1;

    // configuration registers
    logic [EB_W-1:0]   r_extent_bytes;
    logic [ES_W-1:0]   r_extent_sectors;
    logic [BS_W-1:0]   r_bitmap_sectors;
    logic [DOFS_W-1:0] r_data_start;
    logic [CENT_W-1:0] r_catalog_entries;
    // sectors per stored extent, bitmap included
    logic [SPAN_W-1:0] r_span;

    // divider to catalog
    logic                div_valid;
    logic                div_stall;
    t_ctl                div_ctl;
    logic [IDX_W-1:0]    div_q;
    logic [WITHIN_W-1:0] div_within;

    // catalog to address stages
    logic  cat_valid;
    logic  cat_stall;
    t_look cat_look;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_extent_bytes    <= RST_EXTENT_BYTES;
            r_extent_sectors  <= RST_EXTENT_SECTORS;
            r_bitmap_sectors  <= RST_BITMAP_SECTORS;
            r_data_start      <= RST_DATA_START;
            r_catalog_entries <= RST_CATALOG_ENTRIES;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_EXTENT_BYTES:    r_extent_bytes    <= i_cfg_data[EB_W-1:0];
                CFG_EXTENT_SECTORS:  r_extent_sectors  <= i_cfg_data[ES_W-1:0];
                CFG_BITMAP_SECTORS:  r_bitmap_sectors  <= i_cfg_data[BS_W-1:0];
                CFG_DATA_START:      r_data_start      <= i_cfg_data[DOFS_W-1:0];
                CFG_CATALOG_ENTRIES: r_catalog_entries <= i_cfg_data[CENT_W-1:0];
                default: begin
                    // unused indexes are ignored
                end
            endcase
        end
    end

    // follows the config every cycle; a new beat reaches the multiplier much later
    always_ff @(posedge i_clk) begin
        r_span <= SPAN_W'(r_extent_sectors) + SPAN_W'(r_bitmap_sectors);
    end

    // byte offset / extent size, one quotient bit per stage
    sist_div #(
        .IDX_W (IDX_W)
    ) u_div (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_entry_index  (i_entry_index),
        .i_entry_value  (i_entry_value),
        .i_sector       (i_sector),
        .i_extent_bytes (r_extent_bytes),
        .o_valid        (div_valid),
        .i_stall        (div_stall),
        .o_ctl          (div_ctl),
        .o_q            (div_q),
        .o_within       (div_within)
    );

    // catalog writes and slot reads share one port, in beat order
    sist_cat #(
        .CATALOG_DEPTH (CATALOG_DEPTH),
        .IDX_W         (IDX_W)
    ) u_cat (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (div_valid),
        .o_stall           (div_stall),
        .i_ctl             (div_ctl),
        .i_q               (div_q),
        .i_within          (div_within),
        .i_catalog_entries (r_catalog_entries),
        .o_valid           (cat_valid),
        .i_stall           (cat_stall),
        .o_look            (cat_look)
    );

    // status, base = data start + 512 * slot * span, then bitmap and block
    sist_addr u_addr (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (cat_valid),
        .o_stall               (cat_stall),
        .i_look                (cat_look),
        .i_data_start          (r_data_start),
        .i_bitmap_sectors      (r_bitmap_sectors),
        .i_span                (r_span),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_status              (o_status),
        .o_bitmap_byte_address (o_bitmap_byte_address),
        .o_bit_index           (o_bit_index),
        .o_block_address       (o_block_address)
    );

endmodule

>>> sv/sist_div.sv
// ----------------------------------------------------------------------------
// sist_div
// pipelined restoring divider: extent index and sector within extent
// ----------------------------------------------------------------------------
module sist_div #(
    parameter int IDX_W = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_operation,
    input  logic [sist_pkg::WIDX_W-1:0]   i_entry_index,
    input  logic [sist_pkg::VAL_W-1:0]    i_entry_value,
    input  logic [sist_pkg::SECTOR_W-1:0] i_sector,
    input  logic [sist_pkg::EB_W-1:0]     i_extent_bytes,
    output logic                          o_valid,
    input  logic                          i_stall,
    output sist_pkg::t_ctl                o_ctl,
    output logic [IDX_W-1:0]              o_q,
    output logic [sist_pkg::WITHIN_W-1:0] o_within
);
    import sist_pkg::*;

    localparam int DW = (OFS_W > EB_W + IDX_W) ? OFS_W : EB_W + IDX_W;
    localparam int NS = IDX_W + 1;

    logic [NS-1:0]    r_v;
    logic [NS-1:0]    ld;
    t_ctl             r_ctl [NS];
    logic [DW-1:0]    r_rem [NS];
    logic [IDX_W-1:0] r_q   [NS];

    logic [OFS_W-1:0] offset;
    logic [DW-1:0]    lim;
    logic             bad;
    logic [DW-1:0]    sh    [NS];
    logic [NS-1:0]    ge;

    // quotient must fit the index width, else the beat is outside the catalog
    always_comb begin
        offset = OFS_W'(i_sector) << SECTOR_SHIFT;
        lim    = DW'(i_extent_bytes) << IDX_W;
        bad    = (i_extent_bytes == '0) || (DW'(offset) >= lim);
    end

    // one quotient bit per stage, msb first
    always_comb begin
        sh[0] = '0;
        ge[0] = 1'b0;
        for (int s = 1; s < NS; s++) begin
            sh[s] = DW'(i_extent_bytes) << (IDX_W - s);
            ge[s] = r_rem[s-1] >= sh[s];
        end
    end

    // a stage loads when empty or when the next one moves
    always_comb begin
        ld[NS-1] = !r_v[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            ld[k] = !r_v[k] || ld[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ld[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (ld[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_ctl[0] <= '{op: t_op'(i_operation), bad: bad,
                          widx: i_entry_index, wval: i_entry_value};
            r_rem[0] <= DW'(offset);
            r_q[0]   <= '0;
        end
        for (int s = 1; s < NS; s++) begin
            if (ld[s]) begin
                r_ctl[s] <= r_ctl[s-1];
                r_rem[s] <= ge[s] ? (r_rem[s-1] - sh[s]) : r_rem[s-1];
                r_q[s]   <= (r_q[s-1] << 1) | IDX_W'(ge[s]);
            end
        end
    end

    assign o_stall  = !ld[0];
    assign o_valid  = r_v[NS-1];
    assign o_ctl    = r_ctl[NS-1];
    assign o_q      = r_q[NS-1];
    assign o_within = r_rem[NS-1][SECTOR_SHIFT +: WITHIN_W];

endmodule

>>> sv/sist_cat.sv
// ----------------------------------------------------------------------------
// sist_cat
// catalog memory stage: entry writes and slot lookups in beat order
// ----------------------------------------------------------------------------
module sist_cat #(
    parameter int CATALOG_DEPTH = 4096,
    parameter int IDX_W         = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  sist_pkg::t_ctl                i_ctl,
    input  logic [IDX_W-1:0]              i_q,
    input  logic [sist_pkg::WITHIN_W-1:0] i_within,
    input  logic [sist_pkg::CENT_W-1:0]   i_catalog_entries,
    output logic                          o_valid,
    input  logic                          i_stall,
    output sist_pkg::t_look               o_look
);
    import sist_pkg::*;

    logic [VAL_W-1:0]    r_mem [CATALOG_DEPTH];
    logic                r_v;
    t_op                 r_op;
    logic                r_outside;
    logic [WITHIN_W-1:0] r_within;
    logic [VAL_W-1:0]    r_slot;

    logic             ld;
    logic             outside;
    logic             wr_ok;
    logic [IDX_W-1:0] waddr;

    always_comb begin
        ld      = !r_v || !i_stall;
        outside = i_ctl.bad || (32'(i_q) >= 32'(i_catalog_entries))
                  || (32'(i_q) >= 32'(CATALOG_DEPTH));
        wr_ok   = 32'(i_ctl.widx) < 32'(CATALOG_DEPTH);
        waddr   = IDX_W'(i_ctl.widx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (ld) begin
            r_v <= i_valid;
        end
    end

    // single port: a beat either writes its entry or reads its slot
    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_op      <= i_ctl.op;
            r_outside <= outside;
            r_within  <= i_within;
            if (i_valid) begin
                if (i_ctl.op == OP_WRITE) begin
                    if (wr_ok) begin
                        r_mem[waddr] <= i_ctl.wval;
                    end
                end else if (!outside) begin
                    r_slot <= r_mem[i_q];
                end
            end
        end
    end

    assign o_stall = !ld;
    assign o_valid = r_v;
    assign o_look  = '{op: r_op, outside: r_outside, slot: r_slot, ext_sec: r_within};

endmodule

>>> sv/sist_addr.sv
// ----------------------------------------------------------------------------
// sist_addr
// status decode and image address arithmetic, three stages
// ----------------------------------------------------------------------------
module sist_addr (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  sist_pkg::t_look               i_look,
    input  logic [sist_pkg::DOFS_W-1:0]   i_data_start,
    input  logic [sist_pkg::BS_W-1:0]     i_bitmap_sectors,
    input  logic [sist_pkg::SPAN_W-1:0]   i_span,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [sist_pkg::STATUS_W-1:0] o_status,
    output logic [sist_pkg::ADDR_W-1:0]   o_bitmap_byte_address,
    output logic [sist_pkg::BIT_W-1:0]    o_bit_index,
    output logic [sist_pkg::ADDR_W-1:0]   o_block_address
);
    import sist_pkg::*;

    localparam int NS = 3;

    logic [NS-1:0] r_v;
    logic [NS-1:0] ld;

    // stage a: status and slot product
    t_status             r_a_status;
    logic [PROD_W-1:0]   r_a_prod;
    logic [WITHIN_W-1:0] r_a_within;
    // stage b: extent base and offsets
    t_status             r_b_status;
    logic [ADDR_W-1:0]   r_b_base;
    logic [BMP_OFS_W-1:0] r_b_off_bmp;
    logic [SPAN_W-1:0]   r_b_blk_sec;
    logic [BIT_W-1:0]    r_b_bit;
    // stage c: result
    t_status             r_c_status;
    logic [ADDR_W-1:0]   r_c_bmp;
    logic [BIT_W-1:0]    r_c_bit;
    logic [ADDR_W-1:0]   r_c_blk;

    t_status           n_status;
    logic [PROD_W-1:0] n_prod;
    logic              mapped;

    always_comb begin
        priority if (i_look.op == OP_WRITE) begin
            n_status = ST_WRITTEN;
        end else if (i_look.outside) begin
            n_status = ST_OUTSIDE;
        end else if (i_look.slot == SLOT_UNALLOC) begin
            n_status = ST_UNALLOC;
        end else begin
            n_status = ST_MAPPED;
        end
        n_prod = PROD_W'(i_look.slot) * PROD_W'(i_span);
        mapped = (r_b_status == ST_MAPPED);
    end

    always_comb begin
        ld[NS-1] = !r_v[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            ld[k] = !r_v[k] || ld[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ld[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (ld[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_a_status <= n_status;
            r_a_prod   <= n_prod;
            r_a_within <= i_look.ext_sec;
        end
        if (ld[1]) begin
            r_b_status  <= r_a_status;
            r_b_base    <= ADDR_W'(i_data_start) + (ADDR_W'(r_a_prod) << SECTOR_SHIFT);
            r_b_off_bmp <= r_a_within[WITHIN_W-1:BIT_W];
            r_b_blk_sec <= SPAN_W'(i_bitmap_sectors) + SPAN_W'(r_a_within);
            r_b_bit     <= r_a_within[BIT_W-1:0];
        end
        if (ld[2]) begin
            r_c_status <= r_b_status;
            r_c_bmp    <= mapped ? (r_b_base + ADDR_W'(r_b_off_bmp)) : '0;
            r_c_bit    <= mapped ? r_b_bit : '0;
            r_c_blk    <= mapped ? (r_b_base + (ADDR_W'(r_b_blk_sec) << SECTOR_SHIFT)) : '0;
        end
    end

    assign o_stall               = !ld[0];
    assign o_valid               = r_v[NS-1];
    assign o_status              = r_c_status;
    assign o_bitmap_byte_address = r_c_bmp;
    assign o_bit_index           = r_c_bit;
    assign o_block_address       = r_c_blk;

endmodule

>>> sv/sist_checker.sv
// ----------------------------------------------------------------------------
// sist_checker
// port-level checks of the sparse image sector translator
// ----------------------------------------------------------------------------
`include "sparse_image_sector_translator_assert.svh"

module sist_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_stall,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic [sist_pkg::STATUS_W-1:0]   o_status,
    input logic [sist_pkg::ADDR_W-1:0]     o_bitmap_byte_address,
    input logic [sist_pkg::BIT_W-1:0]      o_bit_index,
    input logic [sist_pkg::ADDR_W-1:0]     o_block_address
);
    import sist_pkg::*;

    logic [STATUS_W+2*ADDR_W+BIT_W-1:0] out_beat;
    logic                               out_zero;
    logic                               unmapped;

    assign out_beat = {o_status, o_bitmap_byte_address, o_bit_index, o_block_address};
    assign out_zero = (o_bitmap_byte_address == '0) && (o_bit_index == '0)
                      && (o_block_address == '0);
    assign unmapped = o_valid && (o_status != ST_MAPPED);

    // a stalled result beat stays put
    `SIST_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `SIST_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall, $stable(out_beat))

    // only mapped results carry addresses
    `SIST_ASSERT_IMPL(a_unmapped_zero, i_clk, i_rst_n, unmapped, out_zero)

    // input backs up only behind a blocked output
    `SIST_ASSERT_IMPL(a_stall_when_full, i_clk, i_rst_n, o_stall, o_valid && i_stall)

endmodule

bind sparse_image_sector_translator sist_checker u_sist_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_valid               (i_valid),
    .o_stall               (o_stall),
    .o_valid               (o_valid),
    .i_stall               (i_stall),
    .o_status              (o_status),
    .o_bitmap_byte_address (o_bitmap_byte_address),
    .o_bit_index           (o_bit_index),
    .o_block_address       (o_block_address)
);
